FILE: rtl/scl3x_pkg.sv
// shared types and the scale3x block function
`timescale 1ns / 1ps

package scl3x_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int CFG_W          = 11;
    localparam int PIX_W          = 8;
    localparam int COORD_W        = 10;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // one source column: rows r-2, r-1 and r
    typedef struct packed {
        pix_t t2;
        pix_t t1;
        pix_t t0;
    } col_t;

    typedef struct packed {
        logic [3:0] mask;
        logic       r_is0;
        logic       r_is1;
        logic       c_is0;
        logic       c_is1;
    } ctl_t;

    typedef struct packed {
        pix_t a, b, c, d, e, f, g, h, i;
    } nb_t;

    typedef struct packed {
        pix_t p0, p1, p2, p3, p4, p5, p6, p7, p8;
    } blk_t;

    function automatic blk_t scale3x(input nb_t n);
        blk_t o;
        o = '{n.e, n.e, n.e, n.e, n.e, n.e, n.e, n.e, n.e};
        if (n.b != n.h && n.d != n.f) begin
            o.p0 = (n.d == n.b) ? n.d : n.e;
            o.p1 = ((n.d == n.b && n.e != n.c) || (n.b == n.f && n.e != n.a)) ? n.b : n.e;
            o.p2 = (n.b == n.f) ? n.f : n.e;
            o.p3 = ((n.d == n.b && n.e != n.g) || (n.d == n.h && n.e != n.a)) ? n.d : n.e;
            o.p5 = ((n.b == n.f && n.e != n.i) || (n.h == n.f && n.e != n.c)) ? n.f : n.e;
            o.p6 = (n.d == n.h) ? n.d : n.e;
            o.p7 = ((n.d == n.h && n.e != n.i) || (n.h == n.f && n.e != n.g)) ? n.h : n.e;
            o.p8 = (n.h == n.f) ? n.f : n.e;
        end
        return o;
    endfunction

endpackage

FILE: rtl/scl3x_line_store.sv
// three-row line store, one write port and two registered read ports
`timescale 1ns / 1ps

module scl3x_line_store #(
    parameter int MAX_WIDTH = scl3x_pkg::DEF_MAX_WIDTH,
    parameter int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [1:0]        wr_slot,
    input  logic [1:0]        rd_slot1,
    input  logic [1:0]        rd_slot2,
    input  logic [CW-1:0]     col,
    input  scl3x_pkg::pix_t   wr_data,
    output scl3x_pkg::pix_t   rd_data1,
    output scl3x_pkg::pix_t   rd_data2
);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW = $clog2(DEPTH);

    scl3x_pkg::pix_t mem [DEPTH];
    scl3x_pkg::pix_t rd1_reg;
    scl3x_pkg::pix_t rd2_reg;
    logic [AW-1:0] wa, ra1, ra2;

    assign wa  = AW'(wr_slot)  * AW'(MAX_WIDTH) + AW'(col);
    assign ra1 = AW'(rd_slot1) * AW'(MAX_WIDTH) + AW'(col);
    assign ra2 = AW'(rd_slot2) * AW'(MAX_WIDTH) + AW'(col);

    always_ff @(posedge aclk) begin
        if (en) begin
            mem[wa] <= wr_data;
            rd1_reg <= mem[ra1];
            rd2_reg <= mem[ra2];
        end
    end

    assign rd_data1 = rd1_reg;
    assign rd_data2 = rd2_reg;

endmodule

FILE: rtl/scl3x_emit.sv
// column window and block issue, one output word per cycle while the receiver is ready
`timescale 1ns / 1ps

module scl3x_emit #(
    parameter int MAX_WIDTH  = scl3x_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = scl3x_pkg::DEF_MAX_HEIGHT,
    parameter int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  scl3x_pkg::ctl_t                   in_ctl,
    input  scl3x_pkg::col_t                   in_col,
    input  logic [CW-1:0]                     in_x,
    input  logic [RW-1:0]                     in_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [scl3x_pkg::COORD_W-1:0]     m_block_col,
    output logic [scl3x_pkg::COORD_W-1:0]     m_block_row,
    output logic [7:0]                        m_top_left,
    output logic [7:0]                        m_top_mid,
    output logic [7:0]                        m_top_right,
    output logic [7:0]                        m_mid_left,
    output logic [7:0]                        m_mid_centre,
    output logic [7:0]                        m_mid_right,
    output logic [7:0]                        m_bottom_left,
    output logic [7:0]                        m_bottom_mid,
    output logic [7:0]                        m_bottom_right,
    output logic                              m_image_done
);
    logic            s2_valid_reg;
    scl3x_pkg::ctl_t ctl_reg;
    logic [CW-1:0]   x_reg;
    logic [RW-1:0]   y_reg;
    scl3x_pkg::col_t col_a_reg, col_b_reg, col_c_reg;

    logic                          m_valid_reg;
    logic [scl3x_pkg::COORD_W-1:0] bcol_reg, brow_reg;
    scl3x_pkg::blk_t               blk_reg;
    logic                          done_reg;

    logic [3:0]      sel;
    logic [3:0]      mask_after;
    logic            out_free, emit_now, last, load;
    logic            upper, right_edge;
    scl3x_pkg::col_t cl, cm, cr;
    scl3x_pkg::nb_t  nb;
    logic [CW-1:0]   ex;
    logic [RW-1:0]   ey;

    assign out_free   = !m_valid_reg || m_ready;
    assign sel        = ctl_reg.mask & (~ctl_reg.mask + 4'd1);
    assign emit_now   = s2_valid_reg && (|ctl_reg.mask) && out_free;
    assign mask_after = emit_now ? (ctl_reg.mask & ~sel) : ctl_reg.mask;
    assign last       = !s2_valid_reg || (mask_after == 4'd0);
    assign in_ready   = last;
    assign load       = in_valid && last;

    // upper: block of row r-1; right_edge: block at column c
    assign upper      = sel[0] || sel[1];
    assign right_edge = sel[1] || sel[3];

    always_comb begin
        if (right_edge) begin
            cl = ctl_reg.c_is0 ? col_c_reg : col_b_reg;
            cm = col_c_reg;
            cr = col_c_reg;
            ex = x_reg;
        end else begin
            cl = ctl_reg.c_is1 ? col_b_reg : col_a_reg;
            cm = col_b_reg;
            cr = col_c_reg;
            ex = x_reg - CW'(1);
        end
        if (upper) begin
            ey   = y_reg - RW'(1);
            nb.a = ctl_reg.r_is1 ? cl.t1 : cl.t2;
            nb.b = ctl_reg.r_is1 ? cm.t1 : cm.t2;
            nb.c = ctl_reg.r_is1 ? cr.t1 : cr.t2;
            nb.d = cl.t1;
            nb.e = cm.t1;
            nb.f = cr.t1;
            nb.g = cl.t0;
            nb.h = cm.t0;
            nb.i = cr.t0;
        end else begin
            ey   = y_reg;
            nb.a = ctl_reg.r_is0 ? cl.t0 : cl.t1;
            nb.b = ctl_reg.r_is0 ? cm.t0 : cm.t1;
            nb.c = ctl_reg.r_is0 ? cr.t0 : cr.t1;
            nb.d = cl.t0;
            nb.e = cm.t0;
            nb.f = cr.t0;
            nb.g = cl.t0;
            nb.h = cm.t0;
            nb.i = cr.t0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            ctl_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (load) begin
                s2_valid_reg <= 1'b1;
                ctl_reg      <= in_ctl;
            end else begin
                if (last) begin
                    s2_valid_reg <= 1'b0;
                end
                ctl_reg.mask <= mask_after;
            end
            m_valid_reg <= emit_now || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg     <= in_x;
            y_reg     <= in_y;
            col_a_reg <= col_b_reg;
            col_b_reg <= col_c_reg;
            col_c_reg <= in_col;
        end
        if (emit_now) begin
            bcol_reg <= scl3x_pkg::COORD_W'(ex);
            brow_reg <= scl3x_pkg::COORD_W'(ey);
            blk_reg  <= scl3x_pkg::scale3x(nb);
            done_reg <= sel[3];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_block_col    = bcol_reg;
    assign m_block_row    = brow_reg;
    assign m_top_left     = blk_reg.p0;
    assign m_top_mid      = blk_reg.p1;
    assign m_top_right    = blk_reg.p2;
    assign m_mid_left     = blk_reg.p3;
    assign m_mid_centre   = blk_reg.p4;
    assign m_mid_right    = blk_reg.p5;
    assign m_bottom_left  = blk_reg.p6;
    assign m_bottom_mid   = blk_reg.p7;
    assign m_bottom_right = blk_reg.p8;
    assign m_image_done   = done_reg;

endmodule

FILE: rtl/scale3x_pixel_art_upscaler.sv
// scale3x upscaler top level: raster counters, line store read stage, block issue
//
// usage
//   s_ channel: one 8-bit palette pixel per word, raster order, image_width
//   by image_height (0 taken as 1, values above the maxima taken as the maxima)
//   m_ channel: one word per 3x3 output block with its source column and row;
//   m_image_done marks the last block of the image
//   cfg port: write image_width (index 0) or image_height (index 1) while idle;
//   each write restarts the stream at pixel (0,0)
//   a block is issued once the pixel below-right of it (clamped) has arrived,
//   so rows lag the input by one row; blocks of row y-1 precede row y
//   a pixel passes the read stage and issue stage registers before its blocks reach m_
//   throughput: one pixel per cycle while each pixel yields at most one block
//   and m_ready is high; a pixel yielding n blocks holds the input while the
//   single output register issues them one per cycle (up to four at image end)
//   reset clears counters, rotation and all valid flags; the line store keeps
//   no reset and needs no clearing pass
//   a stalled receiver holds the output word; one pixel waits in the read
//   stage and s_ready drops until the issue stage drains
`timescale 1ns / 1ps

module scale3x_pixel_art_upscaler #(
    parameter int MAX_WIDTH  = scl3x_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = scl3x_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [scl3x_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_pixel_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [scl3x_pkg::COORD_W-1:0] m_block_col,
    output logic [scl3x_pkg::COORD_W-1:0] m_block_row,
    output logic [7:0]                    m_top_left,
    output logic [7:0]                    m_top_mid,
    output logic [7:0]                    m_top_right,
    output logic [7:0]                    m_mid_left,
    output logic [7:0]                    m_mid_centre,
    output logic [7:0]                    m_mid_right,
    output logic [7:0]                    m_bottom_left,
    output logic [7:0]                    m_bottom_mid,
    output logic [7:0]                    m_bottom_right,
    output logic                          m_image_done
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW = 14;

    logic [scl3x_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [1:0]    rot_reg;

    logic            s1_valid_reg;
    scl3x_pkg::ctl_t s1_ctl_reg;
    logic [CW-1:0]   s1_x_reg;
    logic [RW-1:0]   s1_y_reg;
    scl3x_pkg::pix_t s1_pix_reg;

    logic            accept, e_ready;
    logic [CW-1:0]   wm1;
    logic [RW-1:0]   hm1;
    logic            row_end, last_row;
    logic [1:0]      rot1, rot2;
    scl3x_pkg::pix_t rd1, rd2;
    scl3x_pkg::col_t s1_col;
    scl3x_pkg::ctl_t ctl_next;

    always_comb begin
        if (width_reg == '0) begin
            wm1 = '0;
        end else if (XW'(width_reg) > XW'(MAX_WIDTH)) begin
            wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            wm1 = CW'(width_reg - 1'b1);
        end
        if (height_reg == '0) begin
            hm1 = '0;
        end else if (XW'(height_reg) > XW'(MAX_HEIGHT)) begin
            hm1 = RW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = RW'(height_reg - 1'b1);
        end
    end

    assign s_ready  = !s1_valid_reg || e_ready;
    assign accept   = s_valid && s_ready;
    assign row_end  = (col_reg == wm1);
    assign last_row = (row_reg == hm1);
    assign rot1     = (rot_reg == 2'd0) ? 2'd2 : rot_reg - 2'd1;
    assign rot2     = (rot1 == 2'd0) ? 2'd2 : rot1 - 2'd1;

    always_comb begin
        ctl_next.mask[0] = (row_reg != '0) && (col_reg != '0);
        ctl_next.mask[1] = (row_reg != '0) && row_end;
        ctl_next.mask[2] = last_row && (col_reg != '0);
        ctl_next.mask[3] = last_row && row_end;
        ctl_next.r_is0   = (row_reg == '0);
        ctl_next.r_is1   = (row_reg == RW'(1));
        ctl_next.c_is0   = (col_reg == '0);
        ctl_next.c_is1   = (col_reg == CW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= scl3x_pkg::CFG_W'(16);
            height_reg   <= scl3x_pkg::CFG_W'(16);
            col_reg      <= '0;
            row_reg      <= '0;
            rot_reg      <= 2'd0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    scl3x_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                    scl3x_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                    default: ;
                endcase
                col_reg <= '0;
                row_reg <= '0;
                rot_reg <= 2'd0;
            end else if (accept) begin
                if (row_end) begin
                    col_reg <= '0;
                    if (last_row) begin
                        row_reg <= '0;
                        rot_reg <= 2'd0;
                    end else begin
                        row_reg <= row_reg + RW'(1);
                        rot_reg <= (rot_reg == 2'd2) ? 2'd0 : rot_reg + 2'd1;
                    end
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (e_ready) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg <= ctl_next;
            s1_x_reg   <= col_reg;
            s1_y_reg   <= row_reg;
            s1_pix_reg <= s_pixel_value;
        end
    end

    scl3x_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_store (
        .aclk     (aclk),
        .en       (accept),
        .wr_slot  (rot_reg),
        .rd_slot1 (rot1),
        .rd_slot2 (rot2),
        .col      (col_reg),
        .wr_data  (s_pixel_value),
        .rd_data1 (rd1),
        .rd_data2 (rd2)
    );

    assign s1_col = '{t2: rd2, t1: rd1, t0: s1_pix_reg};

    scl3x_emit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s1_valid_reg),
        .in_ready       (e_ready),
        .in_ctl         (s1_ctl_reg),
        .in_col         (s1_col),
        .in_x           (s1_x_reg),
        .in_y           (s1_y_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_block_col    (m_block_col),
        .m_block_row    (m_block_row),
        .m_top_left     (m_top_left),
        .m_top_mid      (m_top_mid),
        .m_top_right    (m_top_right),
        .m_mid_left     (m_mid_left),
        .m_mid_centre   (m_mid_centre),
        .m_mid_right    (m_mid_right),
        .m_bottom_left  (m_bottom_left),
        .m_bottom_mid   (m_bottom_mid),
        .m_bottom_right (m_bottom_right),
        .m_image_done   (m_image_done)
    );

endmodule

FILE: rtl/scl3x_checker.sv
// port-level checks for the upscaler and their binding
`timescale 1ns / 1ps

module scl3x_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [scl3x_pkg::COORD_W-1:0] m_block_col,
    input logic [scl3x_pkg::COORD_W-1:0] m_block_row,
    input logic [7:0]                    m_top_left,
    input logic                          m_image_done
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid right after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("stalled word dropped");

    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_block_col) && $stable(m_block_row)
            && $stable(m_top_left))
        else $error("stalled word changed");

    a_next_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_image_done |=> !m_valid || m_block_row == '0)
        else $error("word after image end not from row zero");

endmodule

bind scale3x_pixel_art_upscaler scl3x_checker u_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_block_col  (m_block_col),
    .m_block_row  (m_block_row),
    .m_top_left   (m_top_left),
    .m_image_done (m_image_done)
);
